// ===== design/bcu_pkg.sv =====
// Shared types, constants and helper functions of the barometric compensation unit.
package bcu_pkg;

    // Calibration word indexes on the configuration port
    typedef enum logic [3:0] {
        REG_AC1   = 4'd0,
        REG_AC2   = 4'd1,
        REG_AC3   = 4'd2,
        REG_AC4   = 4'd3,
        REG_AC5   = 4'd4,
        REG_AC6   = 4'd5,
        REG_B1_B2 = 4'd6,
        REG_MC_MD = 4'd7
    } t_reg_idx;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned DIV_STAGES  = 32;

    localparam logic [31:0] C_B6_OFFSET  = 32'd4000;
    localparam logic [31:0] C_P_SQ_GAIN  = 32'd3038;
    localparam logic [31:0] C_P_LIN_GAIN = 32'hFFFF_E343; // -7357
    localparam logic [31:0] C_P_OFFSET   = 32'd3791;
    localparam logic [31:0] C_HALF_SCALE = 32'd32768;
    localparam logic [31:0] C_B7_SCALE   = 32'd50000;
    localparam logic signed [31:0] C_T_MAX = 32'sd32767;
    localparam logic signed [31:0] C_T_MIN = -32'sd32768;
    localparam logic signed [31:0] C_P_MAX = 32'sd262143;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
    } t_cal;

    // Queue entry: reading after the temperature front end
    typedef struct packed {
        logic [31:0] x1;
        logic [31:0] den;
        logic [31:0] num;
        logic [18:0] up;
        logic [1:0]  oss;
    } t_fq;

    // Working context carried down the back-end pipeline
    typedef struct packed {
        logic [31:0] x1;
        logic [18:0] up;
        logic [1:0]  oss;
        logic        qneg;
        logic        err;
        logic [31:0] t;
        logic [31:0] b6;
        logic [31:0] sqp;
        logic [31:0] ac2b6;
        logic [31:0] ac3b6;
        logic [31:0] b2sq;
        logic [31:0] b1sq;
        logic [31:0] b3;
        logic [31:0] x3;
        logic [31:0] b4;
        logic [31:0] b7a;
        logic [31:0] b7;
        logic        big;
        logic [31:0] p;
        logic [31:0] pp;
        logic [31:0] m2;
        logic [31:0] x1p;
    } t_ctx;

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(logic [31:0] x, int unsigned s);
        return 32'($signed(x) >>> s);
    endfunction

endpackage

// ===== design/barometric_compensation_unit.sv =====
// Top level of the barometric compensation unit: calibration registers and block wiring.
//
// Takes one raw temperature and pressure reading per transaction and returns the
// compensated temperature (0.1 degree) and pressure (Pa), or a divide error with
// zero results. A new reading can be accepted every cycle unless the input stalls; a
// reading passes through the input register, the four-entry queue between the front
// end and the back end, the two 32-stage pipelined dividers (temperature and pressure)
// and the multiply stages. An output stall freezes the whole back end, and the input
// stalls once the queue is full. Calibration words are written through the
// configuration port (always ready); the user must write them only while no reading
// is in flight, as the block itself does not enforce this.
module barometric_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_raw_temperature,
    input  logic [18:0] i_raw_pressure,
    input  logic [1:0]  i_oversampling,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_temperature,
    output logic [17:0] o_pressure,
    output logic        o_divide_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bcu_pkg::*;

    t_cal r_cal;
    t_fq  push_entry, pop_entry;
    logic push, pop, full, empty;

    assign o_cfg_ready = 1'b1;

    // Write calibration words; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_AC1:   r_cal.ac1   <= i_cfg_data[15:0];
                REG_AC2:   r_cal.ac2   <= i_cfg_data[15:0];
                REG_AC3:   r_cal.ac3   <= i_cfg_data[15:0];
                REG_AC4:   r_cal.ac4   <= i_cfg_data[15:0];
                REG_AC5:   r_cal.ac5   <= i_cfg_data[15:0];
                REG_AC6:   r_cal.ac6   <= i_cfg_data[15:0];
                REG_B1_B2: r_cal.b1_b2 <= i_cfg_data;
                REG_MC_MD: r_cal.mc_md <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bcu_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_oversampling    (i_oversampling),
        .i_cal             (r_cal),
        .o_push            (push),
        .o_entry           (push_entry),
        .i_full            (full)
    );

    bcu_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_empty (empty)
    );

    bcu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cal          (r_cal),
        .i_q_empty      (empty),
        .i_q_entry      (pop_entry),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_temperature  (o_temperature),
        .o_pressure     (o_pressure),
        .o_divide_error (o_divide_error)
    );

endmodule

// ===== design/bcu_fifo.sv =====
// Four-entry queue between the front end and the back-end pipeline.
module bcu_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bcu_pkg::t_fq  i_entry,
    output logic          o_full,
    input  logic          i_pop,
    output bcu_pkg::t_fq  o_entry,
    output logic          o_empty
);
    import bcu_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    t_fq             r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== design/bcu_front.sv =====
// Front end: accepts readings, computes the temperature slope term and divide operands.
module bcu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [15:0]   i_raw_temperature,
    input  logic [18:0]   i_raw_pressure,
    input  logic [1:0]    i_oversampling,
    input  bcu_pkg::t_cal i_cal,
    output logic          o_push,
    output bcu_pkg::t_fq  o_entry,
    input  logic          i_full
);
    import bcu_pkg::*;

    logic        r_fv;
    t_fq         r_f;
    t_fq         n_f;
    logic [31:0] diff, prod;

    assign o_stall = r_fv && i_full;
    assign o_push  = r_fv && !i_full;
    assign o_entry = r_f;

    // Form X1, the divisor X1 + MD and the numerator MC << 11
    always_comb begin
        diff     = {16'd0, i_raw_temperature} - {16'd0, i_cal.ac6};
        prod     = diff * {16'd0, i_cal.ac5};
        n_f.x1   = asr(prod, 15);
        n_f.den  = n_f.x1 + sx16(i_cal.mc_md[15:0]);
        n_f.num  = sx16(i_cal.mc_md[31:16]) << 11;
        n_f.up   = i_raw_pressure;
        n_f.oss  = i_oversampling;
    end

    // Hold the transaction until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (!o_stall) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_f <= n_f;
        end
    end

endmodule

// ===== design/bcu_udiv.sv =====
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
module bcu_udiv (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic [31:0] o_quotient
);
    import bcu_pkg::*;

    logic [31:0] r_rem [DIV_STAGES];
    logic [31:0] r_aq  [DIV_STAGES];
    logic [31:0] r_d   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [31:0] rin, ain, din;
        logic [32:0] trial;
        logic        bit_q;
        logic [32:0] diff;

        if (k == 0) begin : g_first
            assign rin = '0;
            assign ain = i_dividend;
            assign din = i_divisor;
        end else begin : g_next
            assign rin = r_rem[k-1];
            assign ain = r_aq[k-1];
            assign din = r_d[k-1];
        end

        // Compare the shifted remainder against the divisor and subtract
        always_comb begin
            trial = {rin, ain[31]};
            diff  = trial - {1'b0, din};
            bit_q = (trial >= {1'b0, din});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= bit_q ? diff[31:0] : trial[31:0];
                r_aq[k]  <= {ain[30:0], bit_q};
                r_d[k]   <= din;
            end
        end
    end

    assign o_quotient = r_aq[DIV_STAGES-1];

endmodule

// ===== design/bcu_back.sv =====
// Back end: temperature divide, pressure polynomial, pressure divide and output register.
module bcu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bcu_pkg::t_cal i_cal,
    input  logic          i_q_empty,
    input  bcu_pkg::t_fq  i_q_entry,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [15:0]   o_temperature,
    output logic [17:0]   o_pressure,
    output logic          o_divide_error
);
    import bcu_pkg::*;

    logic adv;
    logic r_va, r_vb, r_vc, r_vm1, r_vm2, r_vs, r_vm3, r_vm4, r_vpo, r_vm5, r_vm6, r_ov;
    logic [DIV_STAGES-1:0] r_vd1, r_vd2;

    t_fq  r_a;
    t_ctx r_b, r_c, r_m1, r_m2, r_s, r_m3, r_m4, r_po, r_m5, r_m6;
    t_ctx n_b, n_c, n_m1, n_m2, n_s, n_m3, n_m4, n_po, n_m5, n_m6;
    t_ctx r_d1 [DIV_STAGES];
    t_ctx r_d2 [DIV_STAGES];
    logic [31:0] r_ma, r_mb, n_ma, n_mb;
    logic [31:0] uq1, uq2, div2_a;

    logic [15:0] r_temp, n_temp;
    logic [17:0] r_pres, n_pres;
    logic        r_err;

    // Whole pipeline moves when the output register can load
    assign adv   = !(r_ov && i_stall);
    assign o_pop = adv && !i_q_empty;

    assign o_valid        = r_ov;
    assign o_temperature  = r_temp;
    assign o_pressure     = r_pres;
    assign o_divide_error = r_err;

    // Take magnitudes for the signed temperature divide
    always_comb begin
        n_b      = '0;
        n_b.x1   = r_a.x1;
        n_b.up   = r_a.up;
        n_b.oss  = r_a.oss;
        n_b.qneg = r_a.num[31] ^ r_a.den[31];
        n_b.err  = (r_a.den == '0);
        n_ma     = r_a.num[31] ? (32'd0 - r_a.num) : r_a.num;
        n_mb     = r_a.den[31] ? (32'd0 - r_a.den) : r_a.den;
    end

    bcu_udiv u_div_t (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend (r_ma),
        .i_divisor  (r_mb),
        .o_quotient (uq1)
    );

    // Restore quotient sign, form B5, temperature and B6
    always_comb begin
        logic [31:0] x2, b5;
        n_c   = r_d1[DIV_STAGES-1];
        x2    = n_c.qneg ? (32'd0 - uq1) : uq1;
        b5    = n_c.x1 + x2;
        n_c.t  = asr(b5 + 32'd8, 4);
        n_c.b6 = b5 - C_B6_OFFSET;
    end

    // Products of B6
    always_comb begin
        n_m1       = r_c;
        n_m1.sqp   = r_c.b6 * r_c.b6;
        n_m1.ac2b6 = sx16(i_cal.ac2) * r_c.b6;
        n_m1.ac3b6 = sx16(i_cal.ac3) * r_c.b6;
    end

    // Products of the squared term
    always_comb begin
        logic [31:0] sq;
        n_m2      = r_m1;
        sq        = asr(r_m1.sqp, 12);
        n_m2.b2sq = sx16(i_cal.b1_b2[15:0]) * sq;
        n_m2.b1sq = sx16(i_cal.b1_b2[31:16]) * sq;
    end

    // Offset B3 and sensitivity term X3
    always_comb begin
        logic [31:0] x3a, base;
        n_s    = r_m2;
        x3a    = asr(r_m2.b2sq, 11) + asr(r_m2.ac2b6, 11);
        base   = (sx16(i_cal.ac1) << 2) + x3a;
        n_s.b3 = asr((base << r_m2.oss) + 32'd2, 2);
        n_s.x3 = asr(asr(r_m2.ac3b6, 13) + asr(r_m2.b1sq, 16) + 32'd2, 2);
    end

    // Sensitivity B4 and the pressure difference
    always_comb begin
        logic [31:0] prod;
        n_m3     = r_s;
        prod     = {16'd0, i_cal.ac4} * (r_s.x3 + C_HALF_SCALE);
        n_m3.b4  = prod >> 15;
        n_m3.b7a = {13'd0, r_s.up} - r_s.b3;
    end

    // Scale by the oversampling step; flag a zero sensitivity
    always_comb begin
        n_m4     = r_m3;
        n_m4.b7  = r_m3.b7a * (C_B7_SCALE >> r_m3.oss);
        n_m4.err = r_m3.err || (r_m3.b4 == '0);
    end

    // Pick the divide form by the top bit of B7
    always_comb begin
        div2_a = r_m4.b7[31] ? r_m4.b7 : {r_m4.b7[30:0], 1'b0};
    end

    bcu_udiv u_div_p (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend (div2_a),
        .i_divisor  (r_m4.b4),
        .o_quotient (uq2)
    );

    always_comb begin
        n_po     = r_d2[DIV_STAGES-1];
        n_po.big = n_po.b7[31];
        n_po.p   = n_po.big ? {uq2[30:0], 1'b0} : uq2;
    end

    // Square and linear terms of the pressure correction
    always_comb begin
        logic [31:0] pa;
        n_m5    = r_po;
        pa      = asr(r_po.p, 8);
        n_m5.pp = pa * pa;
        n_m5.m2 = C_P_LIN_GAIN * r_po.p;
    end

    always_comb begin
        n_m6     = r_m5;
        n_m6.x1p = asr(r_m5.pp * C_P_SQ_GAIN, 16);
    end

    // Final correction, saturation, and zero results on a divide error
    always_comb begin
        logic [31:0] pf;
        logic signed [31:0] ts, ps;
        pf = r_m6.p + asr(r_m6.x1p + asr(r_m6.m2, 16) + C_P_OFFSET, 4);
        ts = $signed(r_m6.t);
        ps = $signed(pf);
        if (ts > C_T_MAX)      n_temp = C_T_MAX[15:0];
        else if (ts < C_T_MIN) n_temp = C_T_MIN[15:0];
        else                   n_temp = ts[15:0];
        if (ps < 0)            n_pres = '0;
        else if (ps > C_P_MAX) n_pres = C_P_MAX[17:0];
        else                   n_pres = ps[17:0];
        if (r_m6.err) begin
            n_temp = '0;
            n_pres = '0;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a   <= i_q_entry;
            r_b   <= n_b;
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_d1[0] <= r_b;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_d1[i] <= r_d1[i-1];
            end
            r_c   <= n_c;
            r_m1  <= n_m1;
            r_m2  <= n_m2;
            r_s   <= n_s;
            r_m3  <= n_m3;
            r_m4  <= n_m4;
            r_d2[0] <= r_m4;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_d2[i] <= r_d2[i-1];
            end
            r_po  <= n_po;
            r_m5  <= n_m5;
            r_m6  <= n_m6;
            r_temp <= n_temp;
            r_pres <= n_pres;
            r_err  <= r_m6.err;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
            r_vd1 <= '0;
            r_vc  <= 1'b0;
            r_vm1 <= 1'b0;
            r_vm2 <= 1'b0;
            r_vs  <= 1'b0;
            r_vm3 <= 1'b0;
            r_vm4 <= 1'b0;
            r_vd2 <= '0;
            r_vpo <= 1'b0;
            r_vm5 <= 1'b0;
            r_vm6 <= 1'b0;
            r_ov  <= 1'b0;
        end else if (adv) begin
            r_va  <= !i_q_empty;
            r_vb  <= r_va;
            r_vd1 <= {r_vd1[DIV_STAGES-2:0], r_vb};
            r_vc  <= r_vd1[DIV_STAGES-1];
            r_vm1 <= r_vc;
            r_vm2 <= r_vm1;
            r_vs  <= r_vm2;
            r_vm3 <= r_vs;
            r_vm4 <= r_vm3;
            r_vd2 <= {r_vd2[DIV_STAGES-2:0], r_vm4};
            r_vpo <= r_vd2[DIV_STAGES-1];
            r_vm5 <= r_vpo;
            r_vm6 <= r_vm5;
            r_ov  <= r_vm6;
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the barometric compensation unit: directed table plus random phases.
module tb_top;
    import bcu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE = 120;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RAND_PHASES = 10;
    localparam int unsigned PHASE_ITEMS = 115;

    // Calibration sets used by the directed table
    localparam logic [2:0] CAL_RESET = 3'd0;
    localparam logic [2:0] CAL_TYPICAL = 3'd1;
    localparam logic [2:0] CAL_NO_SENS = 3'd2;
    localparam logic [2:0] CAL_MAX = 3'd3;
    localparam logic [2:0] CAL_MIN = 3'd4;

    typedef logic [31:0] cal_words_t [8];

    typedef struct packed {
        logic [15:0] temperature;
        logic [17:0] pressure;
        logic        divide_error;
    } reading_t;

    typedef struct {
        logic [2:0]  cal_set;
        logic [15:0] ut;
        logic [18:0] up;
        logic [1:0]  oss;
        bit          err_row;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_raw_temperature;
    logic [18:0] i_raw_pressure;
    logic [1:0]  i_oversampling;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_temperature;
    logic [17:0] o_pressure;
    logic        o_divide_error;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // Side info that travels with the offered reading
    bit          row_err;
    logic [31:0] cal_shadow [8];
    reading_t    readings_due[$];
    int unsigned mismatches;
    int unsigned cycles;
    bit          hold_req;
    bit          rx_calm;
    bit          tx_calm;
    dir_row_t    dir_tab [19];

    barometric_compensation_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_raw_temperature(i_raw_temperature),
        .i_raw_pressure   (i_raw_pressure),
        .i_oversampling   (i_oversampling),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_temperature    (o_temperature),
        .o_pressure       (o_pressure),
        .o_divide_error   (o_divide_error),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    function automatic logic [31:0] ext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra32(logic [31:0] x, int unsigned s);
        logic signed [31:0] sx;
        sx = x;
        return sx >>> s;
    endfunction

    // Truncating signed divide on 32-bit words, divisor nonzero
    function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? 32'd0 - a : a;
        mb = b[31] ? 32'd0 - b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? 32'd0 - q : q;
    endfunction

    // Compensate one reading against the shadow calibration
    function automatic reading_t compensate(logic [15:0] ut16, logic [18:0] up19,
                                            logic [1:0] oss);
        reading_t r;
        logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t, den;
        logic signed [31:0] ts, ps;
        r = '{temperature: 16'd0, pressure: 18'd0, divide_error: 1'b1};
        ut = {16'd0, ut16};
        up = {13'd0, up19};
        ac1 = ext16(cal_shadow[REG_AC1][15:0]);
        ac2 = ext16(cal_shadow[REG_AC2][15:0]);
        ac3 = ext16(cal_shadow[REG_AC3][15:0]);
        ac4 = {16'd0, cal_shadow[REG_AC4][15:0]};
        ac5 = {16'd0, cal_shadow[REG_AC5][15:0]};
        ac6 = {16'd0, cal_shadow[REG_AC6][15:0]};
        b1 = ext16(cal_shadow[REG_B1_B2][31:16]);
        b2 = ext16(cal_shadow[REG_B1_B2][15:0]);
        mc = ext16(cal_shadow[REG_MC_MD][31:16]);
        md = ext16(cal_shadow[REG_MC_MD][15:0]);

        // Temperature
        x1 = sra32((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 32'd0) return r;
        x2 = div_trunc(mc << 11, den);
        b5 = x1 + x2;
        t = sra32(b5 + 32'd8, 4);

        // Pressure
        b6 = b5 - 32'd4000;
        sq = sra32(b6 * b6, 12);
        x1 = sra32(b2 * sq, 11);
        x2 = sra32(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sra32(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = sra32(ac3 * b6, 13);
        x2 = sra32(b1 * sq, 16);
        x3 = sra32(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 32'd0) return r;
        b7 = (up - b3) * (32'd50000 >> oss);
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = sra32(p, 8) * sra32(p, 8);
        x1 = sra32(x1 * 32'd3038, 16);
        x2 = sra32(32'hFFFF_E343 * p, 16);
        p = p + sra32(x1 + x2 + 32'd3791, 4);

        // Saturate
        ts = t;
        if (ts > 32767) ts = 32767;
        if (ts < -32768) ts = -32768;
        ps = p;
        if (ps > 262143) ps = 262143;
        if (ps < 0) ps = 0;
        r.temperature = ts[15:0];
        r.pressure = ps[17:0];
        r.divide_error = 1'b0;
        return r;
    endfunction

    function automatic cal_words_t typical_cal();
        cal_words_t w;
        w[REG_AC1] = 32'd408;
        w[REG_AC2] = 32'h0000_FFB8;
        w[REG_AC3] = 32'h0000_C7D1;
        w[REG_AC4] = 32'd32741;
        w[REG_AC5] = 32'd32757;
        w[REG_AC6] = 32'd23153;
        w[REG_B1_B2] = 32'h182E_0004;
        w[REG_MC_MD] = 32'hDDF9_0B34;
        return w;
    endfunction

    function automatic cal_words_t table_cal(logic [2:0] set);
        cal_words_t w;
        w = typical_cal();
        case (set)
            CAL_NO_SENS: begin
                w[REG_AC4] = 32'd0;
            end
            CAL_MAX: begin
                for (int i = 0; i < 3; i++) w[i] = 32'h0000_7FFF;
                for (int i = 3; i < 6; i++) w[i] = 32'h0000_FFFF;
                w[REG_B1_B2] = 32'h7FFF_7FFF;
                w[REG_MC_MD] = 32'h7FFF_7FFF;
            end
            CAL_MIN: begin
                for (int i = 0; i < 3; i++) w[i] = 32'h0000_8000;
                for (int i = 3; i < 6; i++) w[i] = 32'h0000_0000;
                w[REG_B1_B2] = 32'h8000_8000;
                w[REG_MC_MD] = 32'h8000_8000;
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    // Random calibration: mostly near the typical part, sometimes wild or at the corners
    function automatic cal_words_t random_cal();
        cal_words_t w;
        int unsigned kind;
        logic [15:0] corner [4];
        corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        w = typical_cal();
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++) begin
            if (kind == 0) begin
                w[i] = $urandom;
            end else if (kind == 1) begin
                w[i] = {corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)]};
            end else if (i < 6) begin
                w[i] = {16'($urandom), w[i][15:0] + 16'($urandom_range(0, 2047)) - 16'd1024};
            end else begin
                w[i][31:16] = w[i][31:16] + 16'($urandom_range(0, 1023)) - 16'd512;
                w[i][15:0] = w[i][15:0] + 16'($urandom_range(0, 63)) - 16'd32;
            end
        end
        return w;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Track calibration writes, predict accepted readings, check results
    always @(posedge i_clk) begin
        reading_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index <= REG_AC6) cal_shadow[i_cfg_index] = {16'd0, i_cfg_data[15:0]};
                else if (i_cfg_index <= REG_MC_MD) cal_shadow[i_cfg_index] = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                if (row_err) readings_due.push_back('{16'd0, 18'd0, 1'b1});
                else readings_due.push_back(compensate(i_raw_temperature, i_raw_pressure,
                                                       i_oversampling));
            end
            if (o_valid && !i_stall) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: unexpected result t=%h p=%h err=%b", $time,
                             o_temperature, o_pressure, o_divide_error);
                    mismatches++;
                end else begin
                    want = readings_due.pop_front();
                    if (o_temperature !== want.temperature) begin
                        $display("%0t: temperature expected %h actual %h", $time,
                                 want.temperature, o_temperature);
                        mismatches++;
                    end
                    if (o_pressure !== want.pressure) begin
                        $display("%0t: pressure expected %h actual %h", $time,
                                 want.pressure, o_pressure);
                        mismatches++;
                    end
                    if (o_divide_error !== want.divide_error) begin
                        $display("%0t: divide_error expected %b actual %b", $time,
                                 want.divide_error, o_divide_error);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        int unsigned n;
        i_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            n = rx_calm ? 0 : $urandom_range(0, 11);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_valid && !i_stall) && !hold_req) @(posedge i_clk);
        end
    end

    task automatic write_cal(cal_words_t w);
        for (int i = 0; i < 9; i++) begin
            i_cfg_valid <= 1'b1;
            if (i < 8) begin
                i_cfg_index <= i[3:0];
                i_cfg_data <= w[i];
            end else begin
                // Index past the last register: must be ignored
                i_cfg_index <= 4'($urandom_range(8, 15));
                i_cfg_data <= $urandom;
            end
            @(posedge i_clk);
            while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_reading(logic [15:0] ut, logic [18:0] up, logic [1:0] oss, bit err);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_temperature <= ut;
        i_raw_pressure <= up;
        i_oversampling <= oss;
        row_err <= err;
        @(posedge i_clk);
        while (!(i_valid && !o_stall)) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        logic [2:0]  cur_set;
        logic [15:0] ut;
        logic [18:0] up;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_raw_temperature = 16'd0;
        i_raw_pressure = 19'd0;
        i_oversampling = 2'd0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 4'd0;
        i_cfg_data = 32'd0;
        row_err = 1'b0;
        hold_req = 1'b0;
        rx_calm = 1'b0;
        tx_calm = 1'b0;
        for (int i = 0; i < 8; i++) cal_shadow[i] = 32'd0;
        dir_tab = '{
            '{CAL_RESET, 16'd0, 19'd0, 2'd0, 1'b1},
            '{CAL_RESET, 16'd65535, 19'd524287, 2'd3, 1'b1},
            '{CAL_RESET, 16'd27898, 19'd23843, 2'd1, 1'b1},
            '{CAL_TYPICAL, 16'd27898, 19'd23843, 2'd0, 1'b0},
            '{CAL_TYPICAL, 16'd0, 19'd0, 2'd0, 1'b0},
            '{CAL_TYPICAL, 16'd65535, 19'd524287, 2'd3, 1'b0},
            '{CAL_TYPICAL, 16'd0, 19'd524287, 2'd1, 1'b0},
            '{CAL_TYPICAL, 16'd65535, 19'd0, 2'd2, 1'b0},
            '{CAL_TYPICAL, 16'd27898, 19'd23843, 2'd1, 1'b0},
            '{CAL_TYPICAL, 16'd27898, 19'd23843, 2'd2, 1'b0},
            '{CAL_TYPICAL, 16'd27898, 19'd23843, 2'd3, 1'b0},
            '{CAL_NO_SENS, 16'd27898, 19'd23843, 2'd0, 1'b1},
            '{CAL_NO_SENS, 16'd30000, 19'd400000, 2'd3, 1'b1},
            '{CAL_MAX, 16'd0, 19'd0, 2'd0, 1'b0},
            '{CAL_MAX, 16'd65535, 19'd524287, 2'd3, 1'b0},
            '{CAL_MAX, 16'd32768, 19'd262144, 2'd1, 1'b0},
            '{CAL_MIN, 16'd0, 19'd0, 2'd0, 1'b0},
            '{CAL_MIN, 16'd65535, 19'd524287, 2'd3, 1'b0},
            '{CAL_MIN, 16'd12345, 19'd99999, 2'd2, 1'b0}
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; recalibrate whenever the set changes
        cur_set = CAL_RESET;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].cal_set != cur_set) begin
                i_valid <= 1'b0;
                drain();
                cur_set = dir_tab[k].cal_set;
                write_cal(table_cal(cur_set));
            end
            send_reading(dir_tab[k].ut, dir_tab[k].up, dir_tab[k].oss, dir_tab[k].err_row);
        end

        // Random phases
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            i_valid <= 1'b0;
            drain();
            write_cal(random_cal());
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (ph == 3) begin
                // Back the block up: receiver holds off while the sender streams
                tx_calm = 1'b1;
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 4) != 0) ut = 16'd27898 + 16'($urandom_range(0, 16000)) - 16'd8000;
                else ut = 16'($urandom);
                up = 19'($urandom);
                send_reading(ut, up, 2'($urandom_range(0, 3)), 1'b0);
            end
        end
        i_valid <= 1'b0;
        drain();

        if (mismatches == 0 && readings_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (readings_due.size() != 0)
                $display("%0t: %0d results never arrived", $time, readings_due.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== barometric_compensation_unit.f =====
design/bcu_pkg.sv
design/bcu_fifo.sv
design/bcu_front.sv
design/bcu_udiv.sv
design/bcu_back.sv
design/barometric_compensation_unit.sv
test/tb_top.sv
